// ===== hdl/cst_pkg.sv =====
// Package with the constants, codes and character helpers of the CIGAR string tokenizer.
package cst_pkg;

    localparam int LEN_LIMIT_BITS = 28;
    localparam int ACC_W          = LEN_LIMIT_BITS + 1;
    localparam int PROD_W         = ACC_W + 4;
    localparam int OP_LEN_W       = 29;
    localparam int OP_CODE_W      = 4;
    localparam int STATUS_W       = 2;
    localparam int PHASE_W        = 2;
    localparam int CHAR_W         = 8;
    localparam int IN_DATA_W      = 8;
    localparam int OUT_DATA_W     = 40;

    typedef logic [ACC_W-1:0]     t_accum;
    typedef logic [PROD_W-1:0]    t_prod;
    typedef logic [OP_LEN_W-1:0]  t_op_len;
    typedef logic [OP_CODE_W-1:0] t_op_code;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [PHASE_W-1:0]   t_phase;
    typedef logic [CHAR_W-1:0]    t_char;

    localparam t_prod LEN_LIMIT = t_prod'(1) << LEN_LIMIT_BITS;

    localparam t_phase PH_NORMAL     = 2'd0;
    localparam t_phase PH_EMPTY_DONE = 2'd1;
    localparam t_phase PH_DROP       = 2'd2;

    localparam t_status ST_OP    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_ERROR = 2'd2;

    localparam t_op_code OP_M  = 4'd0;
    localparam t_op_code OP_I  = 4'd1;
    localparam t_op_code OP_D  = 4'd2;
    localparam t_op_code OP_N  = 4'd3;
    localparam t_op_code OP_S  = 4'd4;
    localparam t_op_code OP_H  = 4'd5;
    localparam t_op_code OP_P  = 4'd6;
    localparam t_op_code OP_X  = 4'd7;
    localparam t_op_code OP_EQ = 4'd8;
    localparam t_op_code OP_B  = 4'd9;

    localparam t_char CH_STAR  = 8'h2A;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_NINE  = 8'h39;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_CR    = 8'h0D;

    function automatic logic is_op_letter(input t_char c);
        logic r;
        unique case (c)
            "M", "I", "D", "N", "S", "H", "P", "X", "=", "B": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_op_code op_code_of(input t_char c);
        t_op_code r;
        unique case (c)
            "M": r = OP_M;
            "I": r = OP_I;
            "D": r = OP_D;
            "N": r = OP_N;
            "S": r = OP_S;
            "H": r = OP_H;
            "P": r = OP_P;
            "X": r = OP_X;
            "=": r = OP_EQ;
            "B": r = OP_B;
            default: r = OP_M;
        endcase
        return r;
    endfunction

    // Space, and the control characters from tab up to carriage return.
    function automatic logic is_white(input t_char c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== hdl/cigar_string_tokenizer_core.sv =====
// Top level of the CIGAR string tokenizer: one character per transfer in, one result out (operation, empty or error).
// A character is held in the input register; its result, if it produces one, then waits
// in the result register.
// Throughput: one character per cycle; the input register keeps taking characters while a
// result waits, as long as the waiting item produces no result.
// Reset (synchronous, active low) empties both registers and clears the parser state.
module cigar_string_tokenizer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [cst_pkg::IN_DATA_W-1:0] i_s_tdata,  // [7:0] char_in
    input  logic                         i_s_tlast,  // last_char
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [cst_pkg::OUT_DATA_W-1:0] o_m_tdata, // [28:0] op_length, [32:29] op_code
    output logic [cst_pkg::STATUS_W-1:0] o_m_tuser,  // [1:0] status
    output logic                         o_m_tlast   // end_of_string
);

    logic              r_in_valid;
    cst_pkg::t_char    r_in_char;
    logic              r_in_last;

    cst_pkg::t_accum   r_accum,  n_accum;
    logic              r_digits, n_digits;
    logic              r_ops,    n_ops;
    cst_pkg::t_phase   r_phase,  n_phase;

    logic              r_out_valid;
    cst_pkg::t_op_len  r_out_len;
    cst_pkg::t_op_code r_out_code;
    cst_pkg::t_status  r_out_status;
    logic              r_out_eos;

    logic              emit;
    cst_pkg::t_op_len  res_len;
    cst_pkg::t_op_code res_code;
    cst_pkg::t_status  res_status;

    logic              is_digit;
    logic              is_star;
    cst_pkg::t_prod    prod;
    logic              advance;
    logic              in_xfer;

    assign is_digit = (r_in_char >= cst_pkg::CH_ZERO) && (r_in_char <= cst_pkg::CH_NINE);
    assign is_star  = (r_in_char == cst_pkg::CH_STAR);
    assign prod     = (cst_pkg::t_prod'(r_accum) << 3) + (cst_pkg::t_prod'(r_accum) << 1)
                    + cst_pkg::t_prod'(r_in_char[3:0]);

    always_comb begin
        n_accum    = r_accum;
        n_digits   = r_digits;
        n_ops      = r_ops;
        n_phase    = r_phase;
        emit       = 1'b0;
        res_len    = '0;
        res_code   = cst_pkg::OP_M;
        res_status = cst_pkg::ST_ERROR;
        unique case (r_phase)
            cst_pkg::PH_NORMAL: begin
                priority if (is_digit) begin
                    n_accum  = prod[cst_pkg::ACC_W-1:0];
                    n_digits = 1'b1;
                    if ((prod > cst_pkg::LEN_LIMIT) || r_in_last) begin
                        emit    = 1'b1;
                        n_phase = cst_pkg::PH_DROP;
                    end
                end else if ((is_star && r_digits) ||
                             (!is_star && !cst_pkg::is_op_letter(r_in_char))) begin
                    emit    = 1'b1;
                    n_phase = cst_pkg::PH_DROP;
                end else begin
                    emit     = 1'b1;
                    n_accum  = '0;
                    n_digits = 1'b0;
                    priority if (is_star || (r_accum == '0)) begin
                        if (r_ops) begin
                            n_phase = cst_pkg::PH_DROP;
                        end else begin
                            res_status = cst_pkg::ST_EMPTY;
                            n_phase    = cst_pkg::PH_EMPTY_DONE;
                        end
                    end else begin
                        res_len    = cst_pkg::OP_LEN_W'(r_accum);
                        res_code   = cst_pkg::op_code_of(r_in_char);
                        res_status = cst_pkg::ST_OP;
                        n_ops      = 1'b1;
                    end
                end
            end
            cst_pkg::PH_EMPTY_DONE: begin
                if (!cst_pkg::is_white(r_in_char)) begin
                    emit    = 1'b1;
                    n_phase = cst_pkg::PH_DROP;
                end
            end
            default: begin
            end
        endcase
        if (r_in_last) begin
            n_accum  = '0;
            n_digits = 1'b0;
            n_ops    = 1'b0;
            n_phase  = cst_pkg::PH_NORMAL;
        end
    end

    assign advance    = r_in_valid && (!emit || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_accum     <= '0;
            r_digits    <= 1'b0;
            r_ops       <= 1'b0;
            r_phase     <= cst_pkg::PH_NORMAL;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_accum  <= n_accum;
                r_digits <= n_digits;
                r_ops    <= n_ops;
                r_phase  <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_char <= i_s_tdata[cst_pkg::CHAR_W-1:0];
            r_in_last <= i_s_tlast;
        end
        if (advance && emit) begin
            r_out_len    <= res_len;
            r_out_code   <= res_code;
            r_out_status <= res_status;
            r_out_eos    <= r_in_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(cst_pkg::OUT_DATA_W - cst_pkg::OP_LEN_W - cst_pkg::OP_CODE_W){1'b0}},
                         r_out_code, r_out_len};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_eos;

    a_accum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cst_pkg::PH_NORMAL) |-> (cst_pkg::t_prod'(r_accum) <= cst_pkg::LEN_LIMIT))
        else $error("Length accumulator above the limit while parsing.");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=>
            (r_phase == cst_pkg::PH_NORMAL) && !r_ops && !r_digits && (r_accum == '0))
        else $error("Parser state not cleared after the last character.");

    a_op_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == cst_pkg::ST_OP)) |-> (r_out_len != '0))
        else $error("Operation transfer with a zero length.");

    a_non_op_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != cst_pkg::ST_OP)) |->
            ((r_out_len == '0) && (r_out_code == cst_pkg::OP_M)))
        else $error("Empty or error transfer carries a length or a code.");

endmodule
